### hdl/lidar_scan_blend_and_row_check_defines.svh
// ----------------------------------------------------------------------------
// lidar scan blend and row check assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef LIDAR_SCAN_BLEND_AND_ROW_CHECK_DEFINES_SVH
`define LIDAR_SCAN_BLEND_AND_ROW_CHECK_DEFINES_SVH

// same-cycle implication
`define LSBRC_ASSERT_NOW(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("lsbrc assertion failed");

// next-cycle implication
`define LSBRC_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("lsbrc assertion failed");

`endif

### hdl/lsbrc_pkg.sv
// ----------------------------------------------------------------------------
// lsbrc_pkg
// types, register codes, reset values and row decision for the scan blender
// ----------------------------------------------------------------------------
package lsbrc_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int HIT_W      = 11;

  localparam logic [HIT_W-1:0] HIT_MAX = {HIT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MIN    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_MIN = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLL_RADIUS  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_RANGE    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_START  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_START   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_SPAN     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_THRESH   = 4'd7;

  localparam logic [7:0]  RST_BLEND_MIN    = 8'd10;
  localparam logic [7:0]  RST_FALLBACK_MIN = 8'd5;
  localparam logic [15:0] RST_COLL_RADIUS  = 16'd2000;
  localparam logic [15:0] RST_ROW_RANGE    = 16'd3000;
  localparam logic [14:0] RST_RIGHT_START  = 15'd5760;
  localparam logic [14:0] RST_LEFT_START   = 15'd17280;
  localparam logic [14:0] RST_WIN_SPAN     = 15'd1920;
  localparam logic [10:0] RST_HIT_THRESH   = 11'd5;

  localparam logic [2:0] ROW_BOTH  = 3'd0;
  localparam logic [2:0] ROW_LEFT  = 3'd1;
  localparam logic [2:0] ROW_RIGHT = 3'd2;
  localparam logic [2:0] ROW_NONE  = 3'd3;
  localparam logic [2:0] ROW_UNDET = 3'd4;

  typedef struct packed {
    logic [15:0] distance_a;
    logic [7:0]  quality_a;
    logic [14:0] angle_a;
    logic [31:0] stamp_a;
    logic        valid_a;
    logic [15:0] distance_b;
    logic [7:0]  quality_b;
    logic [14:0] angle_b;
    logic [31:0] stamp_b;
    logic        valid_b;
    logic        final_point;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_distance;
    logic [7:0]  out_quality;
    logic [14:0] out_angle;
    logic [31:0] out_stamp;
    logic        out_valid;
    logic        scan_done;
    logic        collision;
    logic [2:0]  row_status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] distance;
    logic [7:0]  quality;
    logic [14:0] angle;
    logic [31:0] stamp;
    logic        valid;
  } point_t;

  typedef struct packed {
    logic [7:0]  blend_min_quality;
    logic [7:0]  fallback_min_quality;
    logic [15:0] collision_radius;
    logic [15:0] row_range_limit;
    logic [14:0] right_window_start;
    logic [14:0] left_window_start;
    logic [14:0] window_span;
    logic [10:0] hit_threshold;
  } cfg_t;

  typedef struct packed {
    logic       collision;
    logic [2:0] row_status;
  } summary_t;

  function automatic logic [2:0] row_decision(input logic [HIT_W-1:0] r,
                                              input logic [HIT_W-1:0] l,
                                              input logic [HIT_W-1:0] t);
    logic [2:0] res;
    if (r >= t && l >= t) begin
      res = ROW_BOTH;
    end else if (r < t && l > t) begin
      res = ROW_LEFT;
    end else if (r > t && l < t) begin
      res = ROW_RIGHT;
    end else if (r < t && l < t) begin
      res = ROW_NONE;
    end else begin
      res = ROW_UNDET;
    end
    return res;
  endfunction

endpackage

### hdl/lsbrc_cfg_regs.sv
// ----------------------------------------------------------------------------
// lsbrc_cfg_regs
// configuration register file, one register per index, writes past the list ignored
// ----------------------------------------------------------------------------
module lsbrc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [lsbrc_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [lsbrc_pkg::CFG_DATA_W-1:0]    wr_data,
  output lsbrc_pkg::cfg_t                     cfg
);
  import lsbrc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_BLEND_MIN:    cfg_nxt.blend_min_quality    = wr_data[7:0];
        CFG_FALLBACK_MIN: cfg_nxt.fallback_min_quality = wr_data[7:0];
        CFG_COLL_RADIUS:  cfg_nxt.collision_radius     = wr_data;
        CFG_ROW_RANGE:    cfg_nxt.row_range_limit      = wr_data;
        CFG_RIGHT_START:  cfg_nxt.right_window_start   = wr_data[14:0];
        CFG_LEFT_START:   cfg_nxt.left_window_start    = wr_data[14:0];
        CFG_WIN_SPAN:     cfg_nxt.window_span          = wr_data[14:0];
        CFG_HIT_THRESH:   cfg_nxt.hit_threshold        = wr_data[10:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blend_min_quality    <= RST_BLEND_MIN;
      cfg_r.fallback_min_quality <= RST_FALLBACK_MIN;
      cfg_r.collision_radius     <= RST_COLL_RADIUS;
      cfg_r.row_range_limit      <= RST_ROW_RANGE;
      cfg_r.right_window_start   <= RST_RIGHT_START;
      cfg_r.left_window_start    <= RST_LEFT_START;
      cfg_r.window_span          <= RST_WIN_SPAN;
      cfg_r.hit_threshold        <= RST_HIT_THRESH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hdl/lsbrc_blend.sv
// ----------------------------------------------------------------------------
// lsbrc_blend
// picks or averages the two scan points by quality
// ----------------------------------------------------------------------------
module lsbrc_blend (
  input  lsbrc_pkg::in_item_t item,
  input  lsbrc_pkg::cfg_t     cfg,
  output lsbrc_pkg::point_t   pt
);
  import lsbrc_pkg::*;

  logic [16:0] sum_dist;
  logic [8:0]  sum_qual;
  logic [15:0] sum_angle;
  logic [32:0] sum_stamp;

  assign sum_dist  = {1'b0, item.distance_a} + {1'b0, item.distance_b};
  assign sum_qual  = {1'b0, item.quality_a}  + {1'b0, item.quality_b};
  assign sum_angle = {1'b0, item.angle_a}    + {1'b0, item.angle_b};
  assign sum_stamp = {1'b0, item.stamp_a}    + {1'b0, item.stamp_b};

  always_comb begin
    if (item.quality_a > cfg.blend_min_quality && item.quality_b > cfg.blend_min_quality) begin
      pt.distance = sum_dist[16:1];
      pt.quality  = sum_qual[8:1];
      pt.angle    = sum_angle[15:1];
      pt.stamp    = sum_stamp[32:1];
      pt.valid    = 1'b1;
    end else if (item.quality_a > cfg.fallback_min_quality) begin
      pt.distance = item.distance_a;
      pt.quality  = item.quality_a;
      pt.angle    = item.angle_a;
      pt.stamp    = item.stamp_a;
      pt.valid    = item.valid_a;
    end else if (item.quality_b > cfg.fallback_min_quality) begin
      pt.distance = item.distance_b;
      pt.quality  = item.quality_b;
      pt.angle    = item.angle_b;
      pt.stamp    = item.stamp_b;
      pt.valid    = item.valid_b;
    end else begin
      pt.distance = item.distance_a;
      pt.quality  = item.quality_a;
      pt.angle    = item.angle_a;
      pt.stamp    = item.stamp_a;
      pt.valid    = 1'b0;
    end
  end

endmodule

### hdl/lsbrc_scan_track.sv
// ----------------------------------------------------------------------------
// lsbrc_scan_track
// per-scan collision flag and row hit counters, summary on the last point
// ----------------------------------------------------------------------------
module lsbrc_scan_track (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  upd,
  input  logic                  fin,
  input  lsbrc_pkg::point_t     pt,
  input  lsbrc_pkg::cfg_t       cfg,
  output lsbrc_pkg::summary_t   summary
);
  import lsbrc_pkg::*;

  logic [HIT_W-1:0] right_hits_r, right_hits_nxt;
  logic [HIT_W-1:0] left_hits_r, left_hits_nxt;
  logic             coll_r, coll_nxt;
  logic [HIT_W-1:0] right_cnt, left_cnt;
  logic             coll_cur;
  logic             hit_ok;
  logic             in_right, in_left;
  logic [15:0]      right_end, left_end;

  assign right_end = {1'b0, cfg.right_window_start} + {1'b0, cfg.window_span};
  assign left_end  = {1'b0, cfg.left_window_start} + {1'b0, cfg.window_span};

  assign in_right = (pt.angle > cfg.right_window_start) && ({1'b0, pt.angle} < right_end);
  assign in_left  = (pt.angle > cfg.left_window_start) && ({1'b0, pt.angle} < left_end);
  assign hit_ok   = (pt.quality > cfg.fallback_min_quality) &&
                    (pt.distance < cfg.row_range_limit);

  assign right_cnt = (hit_ok && in_right && right_hits_r != HIT_MAX) ?
                     right_hits_r + 1'b1 : right_hits_r;
  assign left_cnt  = (hit_ok && in_left && left_hits_r != HIT_MAX) ?
                     left_hits_r + 1'b1 : left_hits_r;
  assign coll_cur  = coll_r | (pt.valid && pt.distance < cfg.collision_radius);

  always_comb begin
    right_hits_nxt = right_hits_r;
    left_hits_nxt  = left_hits_r;
    coll_nxt       = coll_r;
    if (upd) begin
      if (fin) begin
        right_hits_nxt = '0;
        left_hits_nxt  = '0;
        coll_nxt       = 1'b0;
      end else begin
        right_hits_nxt = right_cnt;
        left_hits_nxt  = left_cnt;
        coll_nxt       = coll_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_hits_r <= '0;
      left_hits_r  <= '0;
      coll_r       <= 1'b0;
    end else begin
      right_hits_r <= right_hits_nxt;
      left_hits_r  <= left_hits_nxt;
      coll_r       <= coll_nxt;
    end
  end

  always_comb begin
    if (fin) begin
      summary.collision  = coll_cur;
      summary.row_status = row_decision(right_cnt, left_cnt, cfg.hit_threshold);
    end else begin
      summary.collision  = 1'b0;
      summary.row_status = ROW_BOTH;
    end
  end

endmodule

### hdl/lidar_scan_blend_and_row_check.sv
// ----------------------------------------------------------------------------
// lidar_scan_blend_and_row_check
// Blends matching points of two lidar scans and checks for crop rows.
// Input channel: in_valid / in_stall / in_data, one point pair per beat,
// taken when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall / out_data, one blended point per
// beat, with the scan summary on the beat of the last point.
// Configuration: cfg_valid / cfg_ready / cfg_index / cfg_data; cfg_ready is
// always high, so the sender must write only while no beat is in flight;
// the block itself does not enforce this. An input beat goes into the input
// register, then through blend and tracking logic into the output register.
// Throughput: 1 point per cycle, sustained with no downstream stall.
// When out_stall holds the output register, the input register still takes
// one more beat, then in_stall rises until the output moves on.
// Reset (rst_n, synchronous) empties both registers, clears the scan
// counters and the collision flag, and loads the register defaults.
// ----------------------------------------------------------------------------
module lidar_scan_blend_and_row_check (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  lsbrc_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output lsbrc_pkg::out_item_t             out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lsbrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsbrc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lsbrc_pkg::*;

  cfg_t      cfg;
  in_item_t  s1_item_r;
  logic      s1_vld_r, s1_vld_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic      out_vld_r, out_vld_nxt;
  point_t    pt;
  summary_t  summary;
  logic      accept;
  logic      adv;
  logic      move;

  assign cfg_ready = 1'b1;

  lsbrc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign adv      = !out_vld_r || !out_stall;
  assign move     = s1_vld_r && adv;
  assign in_stall = s1_vld_r && !adv;
  assign accept   = in_valid && !in_stall;

  lsbrc_blend u_blend (
    .item (s1_item_r),
    .cfg  (cfg),
    .pt   (pt)
  );

  lsbrc_scan_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (move),
    .fin     (s1_item_r.final_point),
    .pt      (pt),
    .cfg     (cfg),
    .summary (summary)
  );

  assign s1_vld_nxt  = accept || (s1_vld_r && !move);
  assign out_vld_nxt = move || (out_vld_r && out_stall);

  always_comb begin
    out_item_nxt.out_distance = pt.distance;
    out_item_nxt.out_quality  = pt.quality;
    out_item_nxt.out_angle    = pt.angle;
    out_item_nxt.out_stamp    = pt.stamp;
    out_item_nxt.out_valid    = pt.valid;
    out_item_nxt.scan_done    = s1_item_r.final_point;
    out_item_nxt.collision    = summary.collision;
    out_item_nxt.row_status   = summary.row_status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_data;
    end
    if (move) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule

### hdl/lsbrc_checker.sv
// ----------------------------------------------------------------------------
// lsbrc_checker
// port-level checks on the output channel and the stall path, bound to the top
// ----------------------------------------------------------------------------
`include "lidar_scan_blend_and_row_check_defines.svh"

module lsbrc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input lsbrc_pkg::out_item_t             out_data
);
  import lsbrc_pkg::*;

  // a held beat keeps its payload
  `LSBRC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // input backs up only behind a blocked output beat
  `LSBRC_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

  // summary fields are zero off the last point
  `LSBRC_ASSERT_NOW(a_sum_quiet, clk, rst_n, out_valid && !out_data.scan_done, !out_data.collision && out_data.row_status == ROW_BOTH)

  // row status stays within its codes
  `LSBRC_ASSERT_NOW(a_row_code, clk, rst_n, out_valid, out_data.row_status <= ROW_UNDET)

endmodule

bind lidar_scan_blend_and_row_check lsbrc_checker u_lsbrc_checker (.*);

### dv/lidar_scan_blend_and_row_check_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lidar_scan_blend_and_row_check_tb
// Self-checking bench for the two-scan point blender and row checker.
// Point pairs are sent through the stall handshake while the output side
// stalls at random. Each accepted pair runs through a local model of the
// blend, collision and row-hit logic. Every output beat is compared field by
// field with the oldest prediction. Directed scans come first: point
// selection, window edges and each row status.
// Random scans follow under several register settings, extremes included.
// ----------------------------------------------------------------------------
module lidar_scan_blend_and_row_check_tb;
  import lsbrc_pkg::*;

  localparam int ANGLE_MAX    = 23039;
  localparam int DRAIN_CYCLES = 12;
  localparam int MODE_LOW     = 0;
  localparam int MODE_HIGH    = 1;
  localparam int MODE_RANDOM  = 2;

  localparam logic [CFG_IDX_W-1:0] UNMAPPED_IDX_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_IDX_HI = 4'd15;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cfg_t             active_cfg;
  logic [HIT_W-1:0] right_hits;
  logic [HIT_W-1:0] left_hits;
  logic             collision_seen;
  out_item_t        pending_blends[$];
  int               errors;
  bit               in_gaps_on;
  bit               out_stall_on;
  int               stall_left;

  lidar_scan_blend_and_row_check u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void load_defaults();
    active_cfg.blend_min_quality    = RST_BLEND_MIN;
    active_cfg.fallback_min_quality = RST_FALLBACK_MIN;
    active_cfg.collision_radius     = RST_COLL_RADIUS;
    active_cfg.row_range_limit      = RST_ROW_RANGE;
    active_cfg.right_window_start   = RST_RIGHT_START;
    active_cfg.left_window_start    = RST_LEFT_START;
    active_cfg.window_span          = RST_WIN_SPAN;
    active_cfg.hit_threshold        = RST_HIT_THRESH;
    right_hits     = '0;
    left_hits      = '0;
    collision_seen = 1'b0;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_BLEND_MIN:    active_cfg.blend_min_quality    = data[7:0];
      CFG_FALLBACK_MIN: active_cfg.fallback_min_quality = data[7:0];
      CFG_COLL_RADIUS:  active_cfg.collision_radius     = data;
      CFG_ROW_RANGE:    active_cfg.row_range_limit      = data;
      CFG_RIGHT_START:  active_cfg.right_window_start   = data[14:0];
      CFG_LEFT_START:   active_cfg.left_window_start    = data[14:0];
      CFG_WIN_SPAN:     active_cfg.window_span          = data[14:0];
      CFG_HIT_THRESH:   active_cfg.hit_threshold        = data[10:0];
      default: ;
    endcase
  endfunction

  function automatic bit in_window(logic [14:0] angle, logic [14:0] start);
    logic [15:0] upper;
    upper = {1'b0, start} + {1'b0, active_cfg.window_span};
    return (angle > start) && ({1'b0, angle} < upper);
  endfunction

  function automatic logic [HIT_W-1:0] bump(logic [HIT_W-1:0] hits);
    return (hits == HIT_MAX) ? hits : hits + 1'b1;
  endfunction

  function automatic logic [2:0] row_verdict(logic [HIT_W-1:0] r, logic [HIT_W-1:0] l,
                                             logic [HIT_W-1:0] t);
    if (r >= t && l >= t) return ROW_BOTH;
    if (r < t && l > t) return ROW_LEFT;
    if (r > t && l < t) return ROW_RIGHT;
    if (r < t && l < t) return ROW_NONE;
    return ROW_UNDET;
  endfunction

  function automatic out_item_t blend_and_track(in_item_t p);
    out_item_t   r;
    logic [16:0] dsum;
    logic [8:0]  qsum;
    logic [15:0] asum;
    logic [32:0] ssum;
    r    = '0;
    dsum = {1'b0, p.distance_a} + {1'b0, p.distance_b};
    qsum = {1'b0, p.quality_a} + {1'b0, p.quality_b};
    asum = {1'b0, p.angle_a} + {1'b0, p.angle_b};
    ssum = {1'b0, p.stamp_a} + {1'b0, p.stamp_b};
    if (p.quality_a > active_cfg.blend_min_quality &&
        p.quality_b > active_cfg.blend_min_quality) begin
      r.out_distance = dsum[16:1];
      r.out_quality  = qsum[8:1];
      r.out_angle    = asum[15:1];
      r.out_stamp    = ssum[32:1];
      r.out_valid    = 1'b1;
    end else if (p.quality_b > active_cfg.fallback_min_quality &&
                 !(p.quality_a > active_cfg.fallback_min_quality)) begin
      r.out_distance = p.distance_b;
      r.out_quality  = p.quality_b;
      r.out_angle    = p.angle_b;
      r.out_stamp    = p.stamp_b;
      r.out_valid    = p.valid_b;
    end else begin
      r.out_distance = p.distance_a;
      r.out_quality  = p.quality_a;
      r.out_angle    = p.angle_a;
      r.out_stamp    = p.stamp_a;
      r.out_valid    = (p.quality_a > active_cfg.fallback_min_quality) ? p.valid_a : 1'b0;
    end
    if (r.out_valid && r.out_distance < active_cfg.collision_radius) begin
      collision_seen = 1'b1;
    end
    if (r.out_quality > active_cfg.fallback_min_quality &&
        r.out_distance < active_cfg.row_range_limit) begin
      if (in_window(r.out_angle, active_cfg.right_window_start)) right_hits = bump(right_hits);
      if (in_window(r.out_angle, active_cfg.left_window_start)) left_hits = bump(left_hits);
    end
    if (p.final_point) begin
      r.scan_done    = 1'b1;
      r.collision    = collision_seen;
      r.row_status   = row_verdict(right_hits, left_hits, active_cfg.hit_threshold);
      right_hits     = '0;
      left_hits      = '0;
      collision_seen = 1'b0;
    end
    return r;
  endfunction

  function automatic void flag_error(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= 10) $display("mismatch %s: expected %0h, got %0h", what, want, got);
  endfunction

  task automatic check_beat(out_item_t got);
    out_item_t want;
    if (pending_blends.size() == 0) begin
      flag_error("unexpected beat, stamp", 32'h0, got.out_stamp);
    end else begin
      want = pending_blends.pop_front();
      if (got.out_distance !== want.out_distance)
        flag_error("out_distance", want.out_distance, got.out_distance);
      if (got.out_quality !== want.out_quality)
        flag_error("out_quality", want.out_quality, got.out_quality);
      if (got.out_angle !== want.out_angle)
        flag_error("out_angle", want.out_angle, got.out_angle);
      if (got.out_stamp !== want.out_stamp)
        flag_error("out_stamp", want.out_stamp, got.out_stamp);
      if (got.out_valid !== want.out_valid)
        flag_error("out_valid", want.out_valid, got.out_valid);
      if (got.scan_done !== want.scan_done)
        flag_error("scan_done", want.scan_done, got.scan_done);
      if (got.collision !== want.collision)
        flag_error("collision", want.collision, got.collision);
      if (got.row_status !== want.row_status)
        flag_error("row_status", want.row_status, got.row_status);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_beat(out_data);
  end

  always @(negedge clk) begin
    if (!out_stall_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_point(in_item_t p);
    @(negedge clk);
    if (in_gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    pending_blends.push_back(blend_and_track(p));
  endtask

  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_blends.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t pair_point(
      logic [15:0] da, logic [7:0] qa, logic [14:0] aa, logic [31:0] sa, logic va,
      logic [15:0] db, logic [7:0] qb, logic [14:0] ab, logic [31:0] sb, logic vb,
      logic fin);
    in_item_t p;
    p.distance_a  = da;
    p.quality_a   = qa;
    p.angle_a     = aa;
    p.stamp_a     = sa;
    p.valid_a     = va;
    p.distance_b  = db;
    p.quality_b   = qb;
    p.angle_b     = ab;
    p.stamp_b     = sb;
    p.valid_b     = vb;
    p.final_point = fin;
    return p;
  endfunction

  // scan b too poor to matter, scan a carries the point
  function automatic in_item_t single_point(logic [15:0] d, logic [7:0] q, logic [14:0] a,
                                            logic v, logic fin);
    logic [31:0] junk;
    junk = $urandom;
    return pair_point(d, q, a, $urandom, v, junk[15:0], 8'd0, junk[30:16], $urandom,
                      junk[31], fin);
  endfunction

  function automatic int jitter(int v, int top);
    int x;
    x = v + $urandom_range(0, 2) - 1;
    if (x < 0) x = 0;
    if (x > top) x = top;
    return x;
  endfunction

  function automatic logic [14:0] pick_angle();
    int roll, st, sp, a;
    roll = $urandom_range(0, 99);
    st   = (roll % 2 == 0) ? int'(active_cfg.right_window_start)
                           : int'(active_cfg.left_window_start);
    sp   = int'(active_cfg.window_span);
    if (roll < 75) begin
      a = st + 1 + ((sp > 2) ? int'($urandom_range(0, sp - 2)) : 0);
    end else if (roll < 90) begin
      case ($urandom_range(0, 3))
        0: a = st;
        1: a = st + 1;
        2: a = st + sp - 1;
        default: a = st + sp;
      endcase
    end else begin
      a = $urandom_range(0, ANGLE_MAX);
    end
    if (a < 0) a = 0;
    if (a > ANGLE_MAX) a = ANGLE_MAX;
    return a[14:0];
  endfunction

  function automatic logic [15:0] pick_distance();
    int roll, lim, d;
    roll = $urandom_range(0, 99);
    lim  = int'(active_cfg.row_range_limit);
    if (roll < 55) d = (lim > 0) ? int'($urandom_range(0, lim - 1)) : 0;
    else if (roll < 70) d = jitter(int'(active_cfg.collision_radius), 65535);
    else if (roll < 80) d = jitter(lim, 65535);
    else d = $urandom_range(0, 65535);
    return d[15:0];
  endfunction

  function automatic logic [7:0] pick_quality();
    int roll, q;
    roll = $urandom_range(0, 99);
    if (roll < 15) q = $urandom_range(0, int'(active_cfg.fallback_min_quality));
    else if (roll < 30) q = jitter(int'(active_cfg.blend_min_quality), 255);
    else if (roll < 40) q = jitter(int'(active_cfg.fallback_min_quality) + 1, 255);
    else q = $urandom_range(0, 255);
    return q[7:0];
  endfunction

  function automatic in_item_t random_pair(logic fin, bit noise);
    in_item_t    p;
    int          x;
    logic [31:0] bits_a, bits_b;
    bits_a = $urandom;
    bits_b = $urandom;
    if (noise) begin
      x = $urandom_range(0, ANGLE_MAX);
      p.angle_a = x[14:0];
      x = $urandom_range(0, ANGLE_MAX);
      p.angle_b = x[14:0];
      p.distance_a = bits_a[15:0];
      p.distance_b = bits_b[15:0];
      p.quality_a  = bits_a[23:16];
      p.quality_b  = bits_b[23:16];
    end else begin
      p.angle_a = pick_angle();
      x = jitter(int'(p.angle_a), ANGLE_MAX);
      p.angle_b = x[14:0];
      p.distance_a = pick_distance();
      x = jitter(int'(p.distance_a), 65535);
      p.distance_b = x[15:0];
      p.quality_a = pick_quality();
      p.quality_b = pick_quality();
    end
    p.stamp_a     = $urandom;
    p.stamp_b     = $urandom;
    p.valid_a     = bits_a[24];
    p.valid_b     = bits_b[24];
    p.final_point = fin;
    return p;
  endfunction

  task automatic program_registers(int mode);
    logic [31:0] junk;
    int          v;
    junk = $urandom;
    case (mode)
      MODE_LOW: begin
        cfg_write(CFG_BLEND_MIN, {junk[7:0], 8'd0});
        cfg_write(CFG_FALLBACK_MIN, {junk[15:8], 8'd0});
        cfg_write(CFG_COLL_RADIUS, 16'd0);
        cfg_write(CFG_ROW_RANGE, 16'd0);
        cfg_write(CFG_RIGHT_START, {junk[16], 15'd0});
        cfg_write(CFG_LEFT_START, {junk[17], 15'd0});
        cfg_write(CFG_WIN_SPAN, {junk[18], 15'd0});
        cfg_write(CFG_HIT_THRESH, {junk[23:19], 11'd0});
      end
      MODE_HIGH: begin
        cfg_write(CFG_BLEND_MIN, 16'hFFFF);
        cfg_write(CFG_FALLBACK_MIN, 16'hFFFF);
        cfg_write(CFG_COLL_RADIUS, 16'hFFFF);
        cfg_write(CFG_ROW_RANGE, 16'hFFFF);
        cfg_write(CFG_RIGHT_START, {junk[16], 15'(ANGLE_MAX)});
        cfg_write(CFG_LEFT_START, {junk[17], 15'(ANGLE_MAX)});
        cfg_write(CFG_WIN_SPAN, {junk[18], 15'(ANGLE_MAX)});
        cfg_write(CFG_HIT_THRESH, {junk[23:19], 11'd1024});
      end
      default: begin
        v = $urandom_range(0, 60);
        cfg_write(CFG_BLEND_MIN, {junk[7:0], v[7:0]});
        v = $urandom_range(0, 30);
        cfg_write(CFG_FALLBACK_MIN, {junk[15:8], v[7:0]});
        v = $urandom_range(0, 8000);
        cfg_write(CFG_COLL_RADIUS, v[15:0]);
        v = $urandom_range(0, 12000);
        cfg_write(CFG_ROW_RANGE, v[15:0]);
        v = $urandom_range(0, ANGLE_MAX);
        cfg_write(CFG_RIGHT_START, {junk[16], v[14:0]});
        v = $urandom_range(0, ANGLE_MAX);
        cfg_write(CFG_LEFT_START, {junk[17], v[14:0]});
        v = $urandom_range(1, 4000);
        cfg_write(CFG_WIN_SPAN, {junk[18], v[14:0]});
        v = $urandom_range(0, 8);
        cfg_write(CFG_HIT_THRESH, {junk[23:19], v[10:0]});
        // unmapped indexes go last so an aliased decode would show
        cfg_write(junk[24] ? UNMAPPED_IDX_HI : UNMAPPED_IDX_LO, junk[31:16]);
      end
    endcase
  endtask

  task automatic random_scans(int n, bit allow_idle);
    int sent, len;
    bit noisy;
    sent = 0;
    while (sent < n) begin
      len          = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
      noisy        = ($urandom_range(0, 9) == 0);
      in_gaps_on   = allow_idle && ($urandom_range(0, 3) != 0);
      out_stall_on = allow_idle && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < len; i++) begin
        send_point(random_pair((i == len - 1) && ($urandom_range(0, 19) != 0),
                               noisy || ($urandom_range(0, 19) == 0)));
      end
      sent += len;
    end
  endtask

  task automatic test_point_selection();
    send_point(pair_point(16'hFFFF, 8'd255, 15'(ANGLE_MAX), 32'hFFFFFFFF, 1'b0,
                          16'hFFFF, 8'd255, 15'(ANGLE_MAX), 32'hFFFFFFFF, 1'b0, 1'b0));
    send_point(pair_point(16'd60001, 8'd11, 15'd0, 32'd0, 1'b0,
                          16'd60002, 8'd11, 15'd1, 32'd1, 1'b0, 1'b0));
    send_point(pair_point(16'd40000, 8'd10, 15'd100, 32'h12345678, 1'b0,
                          16'd50000, 8'd255, 15'd200, 32'h9ABCDEF0, 1'b1, 1'b0));
    send_point(pair_point(16'd41000, 8'd6, 15'(ANGLE_MAX), 32'hFFFF0000, 1'b1,
                          16'd9, 8'd200, 15'd5, 32'h0, 1'b0, 1'b0));
    send_point(pair_point(16'd5, 8'd5, 15'd300, 32'h0, 1'b1,
                          16'd45000, 8'd6, 15'd400, 32'h0000FFFF, 1'b1, 1'b0));
    // both scans poor: scan a passes through marked invalid
    send_point(pair_point(16'd100, 8'd5, 15'd6000, 32'h55555555, 1'b1,
                          16'd200, 8'd5, 15'd6000, 32'hAAAAAAAA, 1'b1, 1'b0));
    send_point(pair_point(16'd0, 8'd0, 15'd0, 32'd0, 1'b0,
                          16'd0, 8'd0, 15'd0, 32'd0, 1'b0, 1'b1));
  endtask

  task automatic test_collision_and_windows();
    send_point(pair_point(16'd0, 8'd0, 15'd6000, 32'd7, 1'b1,
                          16'd0, 8'd0, 15'd6000, 32'd8, 1'b1, 1'b0));
    send_point(single_point(16'd2000, 8'd6, 15'd5761, 1'b1, 1'b0));
    send_point(single_point(16'd2999, 8'd6, 15'd5760, 1'b1, 1'b0));
    send_point(single_point(16'd2999, 8'd6, 15'd7679, 1'b1, 1'b0));
    send_point(single_point(16'd2999, 8'd6, 15'd7680, 1'b1, 1'b0));
    send_point(single_point(16'd3000, 8'd6, 15'd5800, 1'b1, 1'b0));
    send_point(single_point(16'd2500, 8'd5, 15'd5800, 1'b1, 1'b0));
    send_point(single_point(16'd100, 8'd6, 15'd18000, 1'b1, 1'b0));
    send_point(single_point(16'hFFFF, 8'd6, 15'd0, 1'b0, 1'b1));
  endtask

  task automatic test_row_status();
    settle_idle();
    cfg_write(CFG_HIT_THRESH, 16'd2);
    // both rows
    send_point(single_point(16'd2500, 8'd200, 15'd6000, 1'b1, 1'b0));
    send_point(single_point(16'd2500, 8'd200, 15'd6001, 1'b1, 1'b0));
    send_point(single_point(16'd2500, 8'd200, 15'd18000, 1'b1, 1'b0));
    send_point(single_point(16'd2500, 8'd200, 15'd18001, 1'b1, 1'b1));
    // left only
    for (int i = 0; i < 3; i++) begin
      send_point(single_point(16'd2500, 8'd200, 15'd17500, 1'b0, i == 2));
    end
    // right only
    for (int i = 0; i < 3; i++) begin
      send_point(single_point(16'd2500, 8'd200, 15'd7000, 1'b0, i == 2));
    end
    // no row
    send_point(single_point(16'd2500, 8'd200, 15'd12000, 1'b0, 1'b1));
    // right at threshold, left below: undetermined
    send_point(single_point(16'd2500, 8'd200, 15'd7000, 1'b0, 1'b0));
    send_point(single_point(16'd2500, 8'd200, 15'd7001, 1'b0, 1'b1));
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 10; ph++) begin
      settle_idle();
      program_registers((ph == 2) ? MODE_LOW : (ph == 5) ? MODE_HIGH : MODE_RANDOM);
      random_scans(150, ph != 9);
    end
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    errors       = 0;
    stall_left   = 0;
    in_gaps_on   = 1'b1;
    out_stall_on = 1'b1;
    load_defaults();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_point_selection();
    test_collision_and_windows();
    test_row_status();
    test_random_traffic();

    in_gaps_on   = 1'b0;
    out_stall_on = 1'b0;
    settle_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_blends.size() == 0) begin
      $display("PASS lidar_scan_blend_and_row_check");
    end else begin
      $display("FAIL lidar_scan_blend_and_row_check");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL lidar_scan_blend_and_row_check");
    $finish;
  end

endmodule
